>>> rtl/fcc_pkg.sv
// Package for the CRC-8 frame checker: configuration and result types,
// verdict and register index codes, and the CRC-8 byte update function.
// No dependencies; used by fcc_cfg_if, the top level, fcc_cfg_regs and fcc_frame_eval.
`default_nettype none

package fcc_pkg;

    localparam int CFG_IDX_W = 2;

    localparam logic [7:0] CRC_POLY = 8'h07;
    localparam logic [7:0] CRC_TOP  = 8'h80;
    localparam logic [7:0] CRC_INIT = 8'h00;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TYPE_MIN      = 2'd0,
        REG_TYPE_MAX      = 2'd1,
        REG_MAX_FRAME_LEN = 2'd2
    } reg_idx_t;

    localparam logic [7:0] TYPE_MIN_RST      = 8'd0;
    localparam logic [7:0] TYPE_MAX_RST      = 8'd255;
    localparam logic [7:0] MAX_FRAME_LEN_RST = 8'd64;

    typedef enum logic [1:0] {
        VERDICT_OK       = 2'd0,
        VERDICT_BAD_LEN  = 2'd1,
        VERDICT_BAD_TYPE = 2'd2,
        VERDICT_BAD_CRC  = 2'd3
    } verdict_t;

    typedef struct packed {
        logic [7:0] type_min;
        logic [7:0] type_max;
        logic [7:0] max_frame_len;
    } cfg_t;

    typedef struct packed {
        logic       is_status;
        logic [7:0] payload_byte;
        verdict_t   verdict;
        logic [7:0] frame_type;
        logic [7:0] payload_count;
    } result_t;

    // One byte through the MSB-first CRC-8 shift register, eight steps.
    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] v;
        v = crc ^ b;
        for (int k = 0; k < 8; k++)
        begin
            if ((v & CRC_TOP) != 8'h00)
            begin
                v = {v[6:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                v = {v[6:0], 1'b0};
            end
        end
        return v;
    endfunction

endpackage

`default_nettype wire

>>> rtl/fcc_in_if.sv
// Valid/ready channel that carries received frame bytes.
// Stands alone; used by the top level of the frame checker.
`default_nettype none

interface fcc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       frame_end;

    modport source (output valid, output rx_byte, output frame_end, input ready);
    modport sink (input valid, input rx_byte, input frame_end, output ready);
endinterface

`default_nettype wire

>>> rtl/fcc_out_if.sv
// Valid/ready channel that carries payload words and end-of-frame status words.
// Stands alone; used by the top level of the frame checker.
`default_nettype none

interface fcc_out_if;
    logic       valid;
    logic       ready;
    logic       is_status;
    logic [7:0] payload_byte;
    logic [1:0] verdict;
    logic [7:0] frame_type;
    logic [7:0] payload_count;

    modport source (output valid, output is_status, output payload_byte, output verdict,
                    output frame_type, output payload_count, input ready);
    modport sink (input valid, input is_status, input payload_byte, input verdict,
                  input frame_type, input payload_count, output ready);
endinterface

`default_nettype wire

>>> rtl/fcc_cfg_if.sv
// Register write channel of the frame checker: valid/ready, index and data.
// Depends on fcc_pkg for the index width.
`default_nettype none

interface fcc_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [fcc_pkg::CFG_IDX_W-1:0] index;
    logic [7:0]                   data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/crc8_frame_checker_unit.sv
// CRC-8 frame checker, top level: input register, frame evaluation, result register.
// A byte passes the input register and then the result register before its word is
// valid on tx. Throughput: one word per cycle while tx is ready; the CRC update and
// checks fit between the registers.
// The type byte yields no word; every other byte yields exactly one.
// Reset clears frame state, both valid flags and sets the registers to their defaults.
// Depends on fcc_pkg, the three channel interfaces, fcc_cfg_regs and fcc_frame_eval.
`default_nettype none

module crc8_frame_checker_unit (
    input  wire logic  clk,
    input  wire logic  rst_n,
    fcc_in_if.sink     rx,
    fcc_out_if.source  tx,
    fcc_cfg_if.sink    cfg
);

    fcc_pkg::cfg_t    cfg_regs;
    fcc_pkg::result_t eval_result;
    logic             eval_has_result;
    logic             advance;

    logic             hold_valid_reg;
    logic             hold_valid_next;
    logic [7:0]       hold_byte_reg;
    logic             hold_end_reg;
    logic             out_valid_reg;
    logic             out_valid_next;
    fcc_pkg::result_t out_result_reg;

    fcc_cfg_regs u_cfg_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (cfg_regs)
    );

    fcc_frame_eval u_frame_eval (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .rx_byte    (hold_byte_reg),
        .frame_end  (hold_end_reg),
        .cfg        (cfg_regs),
        .has_result (eval_has_result),
        .result     (eval_result)
    );

    // A held byte moves on when its word has a free slot, or when it makes no word.
    assign advance  = hold_valid_reg && (!eval_has_result || !out_valid_reg || tx.ready);
    assign rx.ready = !hold_valid_reg || advance;

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        if (rx.valid && rx.ready)
        begin
            hold_valid_next = 1'b1;
        end
        else if (advance)
        begin
            hold_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance && eval_has_result)
        begin
            out_valid_next = 1'b1;
        end
        else if (tx.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx.valid && rx.ready)
        begin
            hold_byte_reg <= rx.rx_byte;
            hold_end_reg  <= rx.frame_end;
        end
        if (advance && eval_has_result)
        begin
            out_result_reg <= eval_result;
        end
    end

    assign tx.valid         = out_valid_reg;
    assign tx.is_status     = out_result_reg.is_status;
    assign tx.payload_byte  = out_result_reg.payload_byte;
    assign tx.verdict       = out_result_reg.verdict;
    assign tx.frame_type    = out_result_reg.frame_type;
    assign tx.payload_count = out_result_reg.payload_count;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !tx.ready) |-> !(advance && eval_has_result))
        else $error("result register overwritten while its word waits");

    a_status_zero_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (tx.valid && tx.is_status) |-> (tx.payload_byte == 8'd0))
        else $error("status word carries a payload byte");

    a_hold_accept_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        !hold_valid_reg |-> rx.ready)
        else $error("input register empty but not ready");

endmodule

`default_nettype wire

>>> rtl/fcc_cfg_regs.sv
// Configuration registers of the frame checker: type range and frame length limit.
// Depends on fcc_pkg and fcc_cfg_if.
`default_nettype none

module fcc_cfg_regs (
    input  wire logic          clk,
    input  wire logic          rst_n,
    fcc_cfg_if.sink            cfg,
    output fcc_pkg::cfg_t      regs
);

    fcc_pkg::cfg_t regs_reg;
    fcc_pkg::cfg_t regs_next;

    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    always_comb
    begin
        regs_next = regs_reg;
        if (cfg.valid)
        begin
            case (fcc_pkg::reg_idx_t'(cfg.index))
                fcc_pkg::REG_TYPE_MIN:      regs_next.type_min      = cfg.data;
                fcc_pkg::REG_TYPE_MAX:      regs_next.type_max      = cfg.data;
                fcc_pkg::REG_MAX_FRAME_LEN: regs_next.max_frame_len = cfg.data;
                default:                    regs_next = regs_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.type_min      <= fcc_pkg::TYPE_MIN_RST;
            regs_reg.type_max      <= fcc_pkg::TYPE_MAX_RST;
            regs_reg.max_frame_len <= fcc_pkg::MAX_FRAME_LEN_RST;
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/fcc_frame_eval.sv
// Frame state (CRC accumulator, byte count, type byte) and the evaluation of
// one byte into a payload word, a status word or nothing. Depends on fcc_pkg.
`default_nettype none

module fcc_frame_eval (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           advance,
    input  wire logic [7:0]     rx_byte,
    input  wire logic           frame_end,
    input  wire fcc_pkg::cfg_t  cfg,
    output logic                has_result,
    output fcc_pkg::result_t    result
);

    logic [7:0] crc_reg;
    logic [7:0] crc_next;
    logic [7:0] count_reg;
    logic [7:0] count_next;
    logic [7:0] type_reg;

    logic       first;
    logic [7:0] frame_len;
    logic [7:0] type_seen;
    logic       len_bad;
    logic       type_bad;
    logic       crc_bad;

    assign first     = (count_reg == 8'd0);
    assign frame_len = (count_reg == 8'hFF) ? 8'hFF : count_reg + 8'd1;
    assign type_seen = first ? 8'd0 : type_reg;
    assign len_bad   = first || (frame_len > cfg.max_frame_len);
    assign type_bad  = (type_seen < cfg.type_min) || (type_seen > cfg.type_max);
    assign crc_bad   = (rx_byte != crc_reg);

    // The type byte is the only byte that produces no word.
    assign has_result = frame_end || !first;

    always_comb
    begin
        result = '0;
        if (frame_end)
        begin
            result.is_status     = 1'b1;
            result.frame_type    = type_seen;
            result.payload_count = first ? 8'd0 : frame_len - 8'd2;
            if (len_bad)
            begin
                result.verdict = fcc_pkg::VERDICT_BAD_LEN;
            end
            else if (type_bad)
            begin
                result.verdict = fcc_pkg::VERDICT_BAD_TYPE;
            end
            else if (crc_bad)
            begin
                result.verdict = fcc_pkg::VERDICT_BAD_CRC;
            end
            else
            begin
                result.verdict = fcc_pkg::VERDICT_OK;
            end
        end
        else if (!first)
        begin
            result.payload_byte = rx_byte;
        end
    end

    always_comb
    begin
        crc_next   = crc_reg;
        count_next = count_reg;
        if (advance)
        begin
            if (frame_end)
            begin
                crc_next   = fcc_pkg::CRC_INIT;
                count_next = 8'd0;
            end
            else
            begin
                crc_next   = fcc_pkg::crc8_update(crc_reg, rx_byte);
                count_next = (count_reg == 8'hFF) ? 8'hFF : count_reg + 8'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg   <= fcc_pkg::CRC_INIT;
            count_reg <= 8'd0;
        end
        else
        begin
            crc_reg   <= crc_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && !frame_end && first)
        begin
            type_reg <= rx_byte;
        end
    end

    a_end_clears_state: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && frame_end) |=> (count_reg == 8'd0) && (crc_reg == fcc_pkg::CRC_INIT))
        else $error("frame state not cleared after the last byte");

    a_short_frame_bad_len: assert property (@(posedge clk) disable iff (!rst_n)
        (frame_end && first) |-> (result.verdict == fcc_pkg::VERDICT_BAD_LEN)
            && (result.frame_type == 8'd0) && (result.payload_count == 8'd0))
        else $error("one-byte frame not reported as bad length");

    a_payload_fields_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (has_result && !frame_end) |-> (result.verdict == fcc_pkg::VERDICT_OK)
            && (result.frame_type == 8'd0) && (result.payload_count == 8'd0))
        else $error("status fields set on a payload word");

    a_count_advances: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && !frame_end && (count_reg != 8'hFF)) |=> (count_reg == $past(count_reg) + 8'd1))
        else $error("byte count did not step on a frame byte");

endmodule

`default_nettype wire
